// ----- rtl/multi_timer_event_table_top_assert.svh -----
// Assertion macros shared by the timer table RTL.
`ifndef MULTI_TIMER_EVENT_TABLE_TOP_ASSERT_SVH
`define MULTI_TIMER_EVENT_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTET_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mtet_pkg.sv -----
package mtet_pkg;

    // Input word kinds.
    localparam logic [1:0] KIND_REG   = 2'd0;
    localparam logic [1:0] KIND_UNREG = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Result word kinds.
    localparam logic [1:0] RES_REG   = 2'd0;
    localparam logic [1:0] RES_UNREG = 2'd1;
    localparam logic [1:0] RES_FIRE  = 2'd2;
    localparam logic [1:0] RES_QUIET = 2'd3;

    // At most this many fire words are reported for one tick.
    localparam int MAX_FIRES = 16;
    localparam int NFW       = $clog2(MAX_FIRES + 1);

    typedef struct packed {
        logic [31:0] countdown;
        logic [31:0] reload;
        logic        one_shot;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [7:0]  slot;
        logic [15:0] tag;
    } res_t;

endpackage

// ----- rtl/mtet_if.sv -----
interface mtet_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] interval;
    logic        one_shot;
    logic [15:0] handler_tag;
    logic [7:0]  slot_id;

    modport source (output valid, kind, interval, one_shot, handler_tag, slot_id,
                    input ready);
    modport sink (input valid, kind, interval, one_shot, handler_tag, slot_id,
                  output ready);
endinterface

interface mtet_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic        ok;
    logic [7:0]  slot;
    logic [15:0] fired_tag;
    logic        last;

    modport source (output valid, result_kind, ok, slot, fired_tag, last,
                    input ready);
    modport sink (input valid, result_kind, ok, slot, fired_tag, last,
                  output ready);
endinterface

// ----- rtl/mtet_ram.sv -----
module mtet_ram
    import mtet_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/multi_timer_event_table_top.sv -----
// Timer table: a packed list of up to MAX_EVENTS countdown timers.
// Command words arrive on cmd: register appends a timer and answers with
// its slot, unregister removes a slot and closes the gap, and tick counts
// every timer down by one. Result words leave on res; the last word caused
// by a command carries last. A tick gives one fire word per expiring timer
// (highest slot first, at most 16) or a single quiet word.
// The block takes one command at a time; cmd.ready is low while it works.
// All timer state sits in one single-port-write, registered-read memory
// that a small sequencer walks, so the memory port sets the timing: a
// register writes its entry at once, an unregister reads and rewrites each
// entry above the slot to shift it down, and a tick reads and writes back
// each timer, with a further shift pass for each one-shot removal.
// The next command word is taken in the cycle after the last result is loaded.
// Result words pass through an output register: while res.ready is low the
// word holds and the sequencer waits only when it has a further word to send.
// Reset empties the table at once (no clearing pass) and drops any word in
// flight; the memory content is left as it was and is never read unwritten.
module multi_timer_event_table_top
    import mtet_pkg::*;
#(
    parameter int MAX_EVENTS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    mtet_cmd_if.sink   cmd,
    mtet_res_if.source res
);

`include "multi_timer_event_table_top_assert.svh"

    localparam int IW   = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CW   = $clog2(MAX_EVENTS + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EVENTS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TRD   = 3'd1;
    localparam logic [2:0] S_TEX   = 3'd2;
    localparam logic [2:0] S_SRD   = 3'd3;
    localparam logic [2:0] S_SWR   = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  walk_reg, walk_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [NFW-1:0] nfire_reg, nfire_next;
    logic           is_tick_reg, is_tick_next;
    logic           pend_v_reg, pend_v_next;
    res_t           pend_reg, pend_next;
    logic           out_v_reg;
    res_t           out_reg;
    logic           out_last_reg;

    logic           we, re;
    logic [IW-1:0]  waddr, raddr;
    entry_t         wdata, rdata;

    logic           push, push_last;
    res_t           push_word;
    logic           out_free;

    logic [CW-1:0]  walk_m1, j_p1;
    logic [IW-1:0]  widx;
    logic [31:0]    dec;
    logic           expire, record, stall;

    mtet_ram #(
        .DEPTH (MAX_EVENTS),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free  = !out_v_reg || res.ready;
    assign walk_m1   = walk_reg - CW'(1);
    assign widx      = walk_m1[IW-1:0];
    assign j_p1      = j_reg + CW'(1);
    assign dec       = rdata.countdown - 32'd1;
    assign expire    = (dec == 32'd0);
    assign record    = expire && (nfire_reg < NFW'(MAX_FIRES));
    // A new fire word must first push the held one out, which needs a free slot.
    assign stall     = record && pend_v_reg && !out_free;
    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        walk_next    = walk_reg;
        j_next       = j_reg;
        nfire_next   = nfire_reg;
        is_tick_next = is_tick_reg;
        pend_v_next  = pend_v_reg;
        pend_next    = pend_reg;
        we           = 1'b0;
        re           = 1'b0;
        waddr        = '0;
        raddr        = '0;
        wdata        = '0;
        push         = 1'b0;
        push_last    = 1'b0;
        push_word    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (cmd.kind)
                        KIND_REG:
                        begin
                            pend_v_next = 1'b1;
                            state_next  = S_FLUSH;
                            if (count_reg >= MAX_CNT)
                            begin
                                pend_next = '{kind: RES_REG, ok: 1'b0, slot: 8'd0,
                                              tag: 16'd0};
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = count_reg[IW-1:0];
                                wdata      = '{countdown: cmd.interval,
                                               reload: cmd.interval,
                                               one_shot: cmd.one_shot,
                                               tag: cmd.handler_tag};
                                count_next = count_reg + CW'(1);
                                pend_next  = '{kind: RES_REG, ok: 1'b1,
                                               slot: 8'(count_reg[IW-1:0]),
                                               tag: 16'd0};
                            end
                        end
                        KIND_UNREG:
                        begin
                            pend_v_next = 1'b1;
                            if (CMPW'(cmd.slot_id) >= CMPW'(count_reg))
                            begin
                                pend_next  = '{kind: RES_UNREG, ok: 1'b0,
                                               slot: cmd.slot_id, tag: 16'd0};
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                pend_next    = '{kind: RES_UNREG, ok: 1'b1,
                                                 slot: cmd.slot_id, tag: 16'd0};
                                count_next   = count_reg - CW'(1);
                                j_next       = CW'(cmd.slot_id);
                                is_tick_next = 1'b0;
                                state_next   = S_SRD;
                            end
                        end
                        KIND_TICK:
                        begin
                            walk_next    = count_reg;
                            nfire_next   = '0;
                            is_tick_next = 1'b1;
                            state_next   = S_TRD;
                        end
                        default:
                        begin
                            // Unused kind: the word is taken and dropped.
                        end
                    endcase
                end
            end
            S_TRD:
            begin
                if (walk_reg == '0)
                begin
                    if (!pend_v_reg)
                    begin
                        pend_next   = '{kind: RES_QUIET, ok: 1'b1, slot: 8'd0,
                                        tag: 16'd0};
                        pend_v_next = 1'b1;
                    end
                    state_next = S_FLUSH;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = widx;
                    state_next = S_TEX;
                end
            end
            S_TEX:
            begin
                if (!stall)
                begin
                    we    = 1'b1;
                    waddr = widx;
                    wdata = '{countdown: expire ? rdata.reload : dec,
                              reload: rdata.reload,
                              one_shot: rdata.one_shot,
                              tag: rdata.tag};
                    if (record)
                    begin
                        if (pend_v_reg)
                        begin
                            push      = 1'b1;
                            push_word = pend_reg;
                        end
                        pend_next   = '{kind: RES_FIRE, ok: 1'b1, slot: 8'(widx),
                                        tag: rdata.tag};
                        pend_v_next = 1'b1;
                        nfire_next  = nfire_reg + NFW'(1);
                    end
                    walk_next = walk_m1;
                    if (expire && rdata.one_shot)
                    begin
                        count_next = count_reg - CW'(1);
                        j_next     = CW'(widx);
                        state_next = S_SRD;
                    end
                    else
                    begin
                        state_next = S_TRD;
                    end
                end
            end
            S_SRD:
            begin
                if (j_reg < count_reg)
                begin
                    re         = 1'b1;
                    raddr      = j_p1[IW-1:0];
                    state_next = S_SWR;
                end
                else
                begin
                    state_next = is_tick_reg ? S_TRD : S_FLUSH;
                end
            end
            S_SWR:
            begin
                we         = 1'b1;
                waddr      = j_reg[IW-1:0];
                wdata      = rdata;
                j_next     = j_p1;
                state_next = S_SRD;
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    push        = 1'b1;
                    push_last   = 1'b1;
                    push_word   = pend_reg;
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            walk_reg    <= '0;
            j_reg       <= '0;
            nfire_reg   <= '0;
            is_tick_reg <= 1'b0;
            pend_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            walk_reg    <= walk_next;
            j_reg       <= j_next;
            nfire_reg   <= nfire_next;
            is_tick_reg <= is_tick_next;
            pend_v_reg  <= pend_v_next;
            if (push)
            begin
                out_v_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (push)
        begin
            out_reg      <= push_word;
            out_last_reg <= push_last;
        end
    end

    assign res.valid       = out_v_reg;
    assign res.result_kind = out_reg.kind;
    assign res.ok          = out_reg.ok;
    assign res.slot        = out_reg.slot;
    assign res.fired_tag   = out_reg.tag;
    assign res.last        = out_last_reg;

    `MTET_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= MAX_CNT,
        "timer count above table depth")
    `MTET_ASSERT_NOW(a_flush_pending, state_reg == S_FLUSH, pend_v_reg,
        "flush state without a held result word")
    `MTET_ASSERT_NOW(a_shift_in_range, state_reg == S_SWR, j_reg < count_reg,
        "shift write beyond occupied slots")
    `MTET_ASSERT_NOW(a_push_free, push, out_free,
        "result word pushed over an unread word")
    `MTET_ASSERT_NEXT(a_fire_bound, state_reg == S_TEX, nfire_reg <= NFW'(MAX_FIRES),
        "too many fire words for one tick")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

// Testbench for the timer table. Command words go in on cmd, result words
// come back on res. A predictor class keeps its own copy of the table,
// works out the result words that each accepted command word must cause,
// and compares every accepted result word against the oldest one still
// pending. Stimulus is a short directed sequence followed by random
// command words in four phases with different idle and stall rates.
module tb_top
    import mtet_pkg::*;
();

    localparam int          TABLE_DEPTH  = 16;
    // Command kind 3 has no meaning; the block must ignore it.
    localparam logic [1:0]  KIND_SPARE   = 2'd3;
    // Cycles without any accepted word before the run is declared hung.
    localparam int          HANG_LIMIT   = 4000;
    // Cycles to keep watching for stray result words once all have come.
    localparam int          DRAIN_CYCLES = 64;
    // Length of the long receiver hold-off that fills the block up.
    localparam int          HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [7:0]  slot;
        logic [15:0] tag;
        logic        last;
    } result_word_t;

    // Predictor of the timer table together with the queue of result words
    // that are still due from the block.
    class timer_table_predictor;
        logic [31:0]  countdown_q [TABLE_DEPTH];
        logic [31:0]  reload_q [TABLE_DEPTH];
        logic         one_shot_q [TABLE_DEPTH];
        logic [15:0]  tag_q [TABLE_DEPTH];
        int           count;
        result_word_t pending_words [$];
        int           errors;
        int           n_reg, n_unreg, n_tick, n_fire, n_quiet, n_full, n_bad;

        function new();
            count = 0;
            errors = 0;
            n_reg = 0;
            n_unreg = 0;
            n_tick = 0;
            n_fire = 0;
            n_quiet = 0;
            n_full = 0;
            n_bad = 0;
        endfunction

        function void push_word(logic [1:0] kind, logic ok, logic [7:0] slot,
                                logic [15:0] tag, logic last);
            result_word_t w;
            w.kind = kind;
            w.ok = ok;
            w.slot = slot;
            w.tag = tag;
            w.last = last;
            pending_words.push_back(w);
        endfunction

        // Removes one entry and closes the gap above it.
        function void drop_entry(int idx);
            int j;
            count--;
            for (j = idx; j < count; j++)
            begin
                countdown_q[j] = countdown_q[j + 1];
                reload_q[j] = reload_q[j + 1];
                one_shot_q[j] = one_shot_q[j + 1];
                tag_q[j] = tag_q[j + 1];
            end
        endfunction

        function void apply_command(logic [1:0] kind, logic [31:0] interval,
                                    logic one_shot, logic [15:0] tag,
                                    logic [7:0] slot_id);
            int i;
            int fires;
            result_word_t w;
            case (kind)
                KIND_REG:
                begin
                    n_reg++;
                    if (count >= TABLE_DEPTH)
                    begin
                        n_full++;
                        push_word(RES_REG, 1'b0, 8'd0, 16'd0, 1'b1);
                    end
                    else
                    begin
                        countdown_q[count] = interval;
                        reload_q[count] = interval;
                        one_shot_q[count] = one_shot;
                        tag_q[count] = tag;
                        push_word(RES_REG, 1'b1, 8'(count), 16'd0, 1'b1);
                        count++;
                    end
                end
                KIND_UNREG:
                begin
                    n_unreg++;
                    if (int'(slot_id) >= count)
                    begin
                        n_bad++;
                        push_word(RES_UNREG, 1'b0, slot_id, 16'd0, 1'b1);
                    end
                    else
                    begin
                        drop_entry(int'(slot_id));
                        push_word(RES_UNREG, 1'b1, slot_id, 16'd0, 1'b1);
                    end
                end
                KIND_TICK:
                begin
                    n_tick++;
                    fires = 0;
                    for (i = count - 1; i >= 0; i--)
                    begin
                        countdown_q[i] = countdown_q[i] - 32'd1;
                        if (countdown_q[i] == 32'd0)
                        begin
                            countdown_q[i] = reload_q[i];
                            push_word(RES_FIRE, 1'b1, 8'(i), tag_q[i], 1'b0);
                            fires++;
                            if (one_shot_q[i])
                                drop_entry(i);
                        end
                    end
                    if (fires == 0)
                    begin
                        n_quiet++;
                        push_word(RES_QUIET, 1'b1, 8'd0, 16'd0, 1'b1);
                    end
                    else
                    begin
                        n_fire += fires;
                        w = pending_words.pop_back();
                        w.last = 1'b1;
                        pending_words.push_back(w);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_field(string field, int want, int got);
            if (want != got)
            begin
                errors++;
                $error("result field %s: expected %0d, got %0d", field, want, got);
            end
        endfunction

        function void match_word(result_word_t got);
            result_word_t want;
            if (pending_words.size() == 0)
            begin
                errors++;
                $error("result word with nothing pending: kind %0d slot %0d tag %0d",
                       got.kind, got.slot, got.tag);
                return;
            end
            want = pending_words.pop_front();
            check_field("result_kind", want.kind, got.kind);
            check_field("ok", want.ok, got.ok);
            check_field("slot", want.slot, got.slot);
            check_field("fired_tag", want.tag, got.tag);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mtet_cmd_if cmd_bus();
    mtet_res_if res_bus();

    multi_timer_event_table_top #(
        .MAX_EVENTS(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd_bus),
        .res(res_bus)
    );

    timer_table_predictor predictor = new();

    // Percentages of cycles in which the sender idles and the receiver
    // stalls; the main sequence changes them from phase to phase.
    int send_idle_pct;
    int stall_pct;
    // While high the receiver refuses every result word.
    logic hold_res;
    int quiet_cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The receiver drops ready at random, or for as long as the hold-off
    // lasts.
    always @(posedge clk)
    begin
        res_bus.ready <= rst_n && !hold_res && ($urandom_range(0, 99) >= stall_pct);
    end

    // Every accepted result word is checked against the oldest pending one.
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
            predictor.match_word({res_bus.result_kind, res_bus.ok, res_bus.slot,
                                  res_bus.fired_tag, res_bus.last});
    end

    // A stretch without any accepted word on either side means the block
    // has hung.
    always @(posedge clk)
    begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("timeout: no word accepted for %0d cycles", HANG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one command word, idling first at the current rate, and waits
    // for its handshake. Valid stays high afterwards so that back-to-back
    // words need no extra assignment; it drops only when the sender idles.
    task automatic send_cmd(logic [1:0] kind, logic [31:0] interval,
                            logic one_shot, logic [15:0] tag, logic [7:0] slot_id);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.kind <= kind;
        cmd_bus.interval <= interval;
        cmd_bus.one_shot <= one_shot;
        cmd_bus.handler_tag <= tag;
        cmd_bus.slot_id <= slot_id;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        predictor.apply_command(kind, interval, one_shot, tag, slot_id);
    endtask

    // Short intervals keep timers firing often; now and then a huge or a
    // zero interval is used, which in practice never expires.
    function automatic logic [31:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 32'($urandom_range(1, 6));
        else if (r < 85)
            return 32'($urandom_range(7, 40));
        else if (r < 95)
            return $urandom;
        else
            return 32'd0;
    endfunction

    // One random command word. The mix leans on the table occupancy so that
    // the table neither stays empty nor stays full, and most unregister
    // words name a slot in use. The fields a kind does not use are random.
    task automatic send_random_cmd();
        int r;
        logic [1:0] kind;
        logic [7:0] slot_id;
        int reg_w;
        int unreg_w;
        r = $urandom_range(0, 99);
        if (predictor.count >= TABLE_DEPTH - 1)
        begin
            reg_w = 15;
            unreg_w = 35;
        end
        else if (predictor.count == 0)
        begin
            reg_w = 60;
            unreg_w = 15;
        end
        else
        begin
            reg_w = 35;
            unreg_w = 20;
        end
        if (r < reg_w)
            kind = KIND_REG;
        else if (r < reg_w + unreg_w)
            kind = KIND_UNREG;
        else
            kind = KIND_TICK;
        if (predictor.count > 0 && $urandom_range(0, 99) < 85)
            slot_id = 8'($urandom_range(0, predictor.count - 1));
        else
            slot_id = 8'($urandom);
        send_cmd(kind, pick_interval(), 1'($urandom), 16'($urandom), slot_id);
        // Occasionally an undefined kind is mixed in as noise.
        if ($urandom_range(0, 99) < 3)
            send_cmd(KIND_SPARE, $urandom, 1'($urandom), 16'($urandom), 8'($urandom));
    endtask

    initial
    begin
        int i;
        int phase;
        clk = 1'b0;
        rst_n = 1'b0;
        hold_res = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        cmd_bus.valid = 1'b0;
        cmd_bus.kind = KIND_REG;
        cmd_bus.interval = 32'd0;
        cmd_bus.one_shot = 1'b0;
        cmd_bus.handler_tag = 16'd0;
        cmd_bus.slot_id = 8'd0;
        res_bus.ready = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty table gives a quiet tick and refuses
        // unregister words, both at slot zero and at the top of the range.
        send_cmd(KIND_TICK, 32'd0, 1'b0, 16'd0, 8'd0);
        send_cmd(KIND_UNREG, 32'd0, 1'b0, 16'd0, 8'd0);
        send_cmd(KIND_UNREG, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 8'd255);
        // A one-shot timer with interval one fires on the next tick and is
        // gone by the tick after.
        send_cmd(KIND_REG, 32'd1, 1'b1, 16'hFFFF, 8'd0);
        send_cmd(KIND_TICK, 32'd0, 1'b0, 16'd0, 8'd0);
        send_cmd(KIND_TICK, 32'd0, 1'b0, 16'd0, 8'd0);
        // A zero interval wraps around and stands for the longest period;
        // the all-ones interval comes right after it.
        send_cmd(KIND_REG, 32'd0, 1'b0, 16'h0000, 8'd0);
        send_cmd(KIND_REG, 32'hFFFF_FFFF, 1'b0, 16'hA5A5, 8'd0);
        send_cmd(KIND_REG, 32'd2, 1'b1, 16'h1234, 8'd0);
        send_cmd(KIND_REG, 32'd2, 1'b0, 16'h5A5A, 8'd0);
        send_cmd(KIND_REG, 32'd1, 1'b0, 16'h0F0F, 8'd0);
        // The second tick fires three timers at once, and the one-shot among
        // them is removed while the walk goes on below it.
        send_cmd(KIND_TICK, 32'd0, 1'b0, 16'd0, 8'd0);
        send_cmd(KIND_TICK, 32'd0, 1'b0, 16'd0, 8'd0);
        // Fill the table with one-shot timers, then try one more.
        while (predictor.count < TABLE_DEPTH)
            send_cmd(KIND_REG, 32'd1, 1'b1, 16'($urandom), 8'd0);
        send_cmd(KIND_REG, 32'd3, 1'b0, 16'hBEEF, 8'd0);
        // Most of the table expires on a single tick.
        send_cmd(KIND_TICK, 32'd0, 1'b0, 16'd0, 8'd0);
        send_cmd(KIND_SPARE, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 8'hFF);
        // Remove from the middle, then empty the table from the bottom.
        send_cmd(KIND_UNREG, 32'd0, 1'b0, 16'd0, 8'd1);
        while (predictor.count > 0)
            send_cmd(KIND_UNREG, 32'd0, 1'b0, 16'd0, 8'd0);

        // Random part in four phases: no idling, sender idling, receiver
        // stalling, and both together.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 47;
                    stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct <= 47;
                end
                default:
                begin
                    send_idle_pct = 9;
                    stall_pct <= 9;
                end
            endcase
            // In the stalling phase the receiver also holds off for a long
            // stretch while command words keep coming, so the output
            // register fills and cmd.ready has to drop.
            if (phase == 2)
            begin
                hold_res <= 1'b1;
                fork
                    begin
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_res <= 1'b0;
                    end
                join_none
            end
            for (i = 0; i < 72; i++)
                send_random_cmd();
        end

        // Let every pending result word come out, then watch a while longer
        // for words that should not be there. Valid drops right after the
        // last handshake so that no word is offered twice.
        cmd_bus.valid <= 1'b0;
        while (predictor.pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d register, %0d unregister and %0d tick words",
                 predictor.n_reg, predictor.n_unreg, predictor.n_tick);
        $display("saw %0d fires, %0d quiet ticks, %0d full and %0d bad-slot replies",
                 predictor.n_fire, predictor.n_quiet, predictor.n_full, predictor.n_bad);
        if (predictor.errors == 0 && predictor.pending_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
